// ===== sv/crsp_pkg.sv =====
// ----------------------------------------------------------------------------
// crsp_pkg
// Shared types, widths and table for the Catmull-Rom point sampler.
// ----------------------------------------------------------------------------
package crsp_pkg;

  localparam int COORD_W = 32;
  localparam int COEF_W  = 36;   // widest cubic coefficient, c = 2p0-5p1+4p2-p3
  localparam int SEG_W   = 6;
  localparam int T_W     = 17;   // Q0.16 with room for t == 1.0
  localparam logic [SEG_W-1:0] SEG_RESET = 6'd8;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [COEF_W-1:0]  coef_t;

  typedef struct packed {
    coord_t z;
    coord_t y;
    coord_t x;
  } point_t;

  typedef struct packed {
    coef_t a;
    coef_t b;
    coef_t c;
    coef_t d;
  } axis_coef_t;

  typedef axis_coef_t [2:0] job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // floor(2^16 / s); entry 0 stands in for s == 1
  localparam logic [T_W-1:0] QTAB [64] = '{
    17'd65536, 17'd65536, 17'd32768, 17'd21845, 17'd16384, 17'd13107, 17'd10922, 17'd9362,
    17'd8192,  17'd7281,  17'd6553,  17'd5957,  17'd5461,  17'd5041,  17'd4681,  17'd4369,
    17'd4096,  17'd3855,  17'd3640,  17'd3449,  17'd3276,  17'd3120,  17'd2978,  17'd2849,
    17'd2730,  17'd2621,  17'd2520,  17'd2427,  17'd2340,  17'd2259,  17'd2184,  17'd2114,
    17'd2048,  17'd1985,  17'd1927,  17'd1872,  17'd1820,  17'd1771,  17'd1724,  17'd1680,
    17'd1638,  17'd1598,  17'd1560,  17'd1524,  17'd1489,  17'd1456,  17'd1424,  17'd1394,
    17'd1365,  17'd1337,  17'd1310,  17'd1285,  17'd1260,  17'd1236,  17'd1213,  17'd1191,
    17'd1170,  17'd1149,  17'd1129,  17'd1110,  17'd1092,  17'd1074,  17'd1057,  17'd1040
  };

  function automatic coef_t ext(input coord_t v);
    return COEF_W'(v);
  endfunction

  function automatic axis_coef_t make_coefs(input coord_t p0, input coord_t p1,
                                            input coord_t p2, input coord_t p3);
    axis_coef_t r;
    r.a = ext(p1) <<< 1;
    r.b = ext(p2) - ext(p0);
    r.c = (ext(p0) <<< 1) - (ext(p1) <<< 2) - ext(p1) + (ext(p2) <<< 2) - ext(p3);
    r.d = ext(p1) - ext(p0) + (ext(p1) <<< 1) - (ext(p2) <<< 1) - ext(p2) + ext(p3);
    return r;
  endfunction

endpackage

// ===== sv/catmull_rom_spline_points_top.sv =====
// ----------------------------------------------------------------------------
// catmull_rom_spline_points_top
// Uniform Catmull-Rom sampler for streamed 3D control points.
// ----------------------------------------------------------------------------
// Control points enter on the s_axis channel (x, y, z in Q16.16, tuser marks
// the first point of a new curve). The first three points of a curve are
// stored; every later point closes a window and yields segments+1 samples on
// m_axis (segments 0 acts as 1), tlast on the sample at t = 1.
// The front end classifies points and builds cubic coefficients, a two-entry
// job queue decouples it from the sample engine. The engine produces one
// sample per cycle while m_axis is not stalled, through a four-stage Horner
// pipeline plus an output register. Each window opens with a setup step
// that pops its job; no new job is taken until the window's last sample
// has issued, so the engine sets the sustained input rate.
// A stalled m_axis freezes the whole pipeline; the queue fills and then
// s_axis_tready drops. Reset clears held-point count and queue, and loads
// segments with 8. Write segments (cfg_we_i) only while the block is idle.
// ----------------------------------------------------------------------------
module catmull_rom_spline_points_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [5:0]  cfg_wdata_i,     // segments
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,    // [31:0] point_x, [63:32] point_y, [95:64] point_z
  input  logic        s_axis_tuser,    // new_curve
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [95:0] m_axis_tdata,    // [31:0] sample_x, [63:32] sample_y, [95:64] sample_z
  output logic        m_axis_tlast     // last_sample
);
  import crsp_pkg::*;

  logic [SEG_W-1:0] seg_q;
  q_stat_t          q_stat;
  logic             push, pop;
  job_t             push_job, head_job;
  point_t           out_point;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_q <= SEG_RESET;
    end else if (cfg_we_i) begin
      seg_q <= cfg_wdata_i;
    end
  end

  crsp_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .in_point_i     (point_t'(s_axis_tdata)),
    .in_new_curve_i (s_axis_tuser),
    .q_stat_i       (q_stat),
    .push_o         (push),
    .push_job_o     (push_job)
  );

  crsp_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .pop_i      (pop),
    .head_job_o (head_job),
    .stat_o     (q_stat)
  );

  crsp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .segments_i  (seg_q),
    .q_stat_i    (q_stat),
    .head_job_i  (head_job),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_point_o (out_point),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = out_point;

endmodule

// ===== sv/crsp_queue.sv =====
// ----------------------------------------------------------------------------
// crsp_queue
// Two-entry job queue between the point front end and the sample engine.
// ----------------------------------------------------------------------------
module crsp_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  crsp_pkg::job_t  push_job_i,
  input  logic            pop_i,
  output crsp_pkg::job_t  head_job_o,
  output crsp_pkg::q_stat_t stat_o
);
  import crsp_pkg::*;

  job_t       mem_q [2];
  logic       wp_q, wp_d, rp_q, rp_d;
  logic [1:0] cnt_q, cnt_d;

  always_comb begin
    wp_d  = wp_q ^ push_i;
    rp_d  = rp_q ^ pop_i;
    cnt_d = cnt_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= push_job_i;
    end
  end

  assign head_job_o   = mem_q[rp_q];
  assign stat_o.full  = cnt_q[1];
  assign stat_o.empty = (cnt_q == 2'd0);

endmodule

// ===== sv/crsp_front.sv =====
// ----------------------------------------------------------------------------
// crsp_front
// Accepts control points, keeps the three latest and turns each full window
// into a job of cubic coefficients.
// ----------------------------------------------------------------------------
module crsp_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  crsp_pkg::point_t  in_point_i,
  input  logic              in_new_curve_i,
  input  crsp_pkg::q_stat_t q_stat_i,
  output logic              push_o,
  output crsp_pkg::job_t    push_job_o
);
  import crsp_pkg::*;

  point_t     hp_q [3];
  logic [1:0] cnt_q, cnt_d, eff_cnt;
  logic       acc;

  assign in_ready_o = !q_stat_i.full;
  assign acc        = in_valid_i && in_ready_o;
  assign eff_cnt    = in_new_curve_i ? 2'd0 : cnt_q;
  assign push_o     = acc && (eff_cnt == 2'd3);

  assign push_job_o[0] = make_coefs(hp_q[0].x, hp_q[1].x, hp_q[2].x, in_point_i.x);
  assign push_job_o[1] = make_coefs(hp_q[0].y, hp_q[1].y, hp_q[2].y, in_point_i.y);
  assign push_job_o[2] = make_coefs(hp_q[0].z, hp_q[1].z, hp_q[2].z, in_point_i.z);

  always_comb begin
    cnt_d = cnt_q;
    if (acc && eff_cnt != 2'd3) begin
      cnt_d = eff_cnt + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      if (eff_cnt == 2'd3) begin
        hp_q[0] <= hp_q[1];
        hp_q[1] <= hp_q[2];
        hp_q[2] <= in_point_i;
      end else begin
        hp_q[eff_cnt] <= in_point_i;
      end
    end
  end

endmodule

// ===== sv/crsp_back.sv =====
// ----------------------------------------------------------------------------
// crsp_back
// Steps t over one window and evaluates the cubic by Horner's rule in a
// four-stage pipeline, one sample per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module crsp_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [crsp_pkg::SEG_W-1:0] segments_i,
  input  crsp_pkg::q_stat_t          q_stat_i,
  input  crsp_pkg::job_t             head_job_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output crsp_pkg::point_t           out_point_o,
  output logic                       out_last_o
);
  import crsp_pkg::*;

  localparam int S1_W = 55;
  localparam int S2_W = 74;
  localparam int S3_W = 93;
  localparam int R_W  = S3_W - 49;

  logic [SEG_W-1:0] seg_eff;
  logic [T_W-1:0]   q0;
  logic [SEG_W-1:0] r0;

  logic             act_q, act_d;
  logic [SEG_W-1:0] j_q, j_d, rem_q, rem_d, r0_q, r0_d;
  logic [T_W-1:0]   t_q, t_d, q0_q, q0_d;
  job_t             job_q;
  logic [SEG_W:0]   rem_sum;
  logic             adv, issue, is_last;

  // pipeline
  logic                     v1_q, v2_q, v3_q, v4_q, ov_q;
  logic                     l1_q, l2_q, l3_q, l4_q, ol_q;
  job_t                     c1_q;
  logic [T_W-1:0]           t1_q, t2_q, t3_q;
  logic signed [S1_W-1:0]   s1_q [3];
  logic signed [S2_W-1:0]   s2_q [3];
  logic signed [S3_W-1:0]   s3_q [3];
  coef_t                    a2_q [3], b2_q [3], a3_q [3];
  coord_t                   o_q [3];

  function automatic coord_t round_sat(input logic signed [S3_W-1:0] s);
    logic signed [S3_W-1:0] sr;
    logic signed [R_W-1:0]  r;
    sr = s + (S3_W'(1) <<< 48);
    r  = R_W'(sr >>> 49);
    if (r > R_W'(signed'({1'b0, {(COORD_W-1){1'b1}}}))) begin
      return {1'b0, {(COORD_W-1){1'b1}}};
    end else if (r < -R_W'(signed'({1'b0, 1'b1, {(COORD_W-1){1'b0}}}))) begin
      return {1'b1, {(COORD_W-1){1'b0}}};
    end
    return COORD_W'(r);
  endfunction

  assign seg_eff = (segments_i == '0) ? SEG_W'(1) : segments_i;
  assign q0      = QTAB[seg_eff];
  assign r0      = SEG_W'(17'd65536 - T_W'(q0 * seg_eff));

  assign adv     = !ov_q || out_ready_i;
  assign pop_o   = !act_q && !q_stat_i.empty;
  assign issue   = act_q && adv;
  assign is_last = (j_q == seg_eff);
  assign rem_sum = {1'b0, rem_q} + {1'b0, r0_q};

  always_comb begin
    act_d = act_q;
    j_d   = j_q;
    t_d   = t_q;
    rem_d = rem_q;
    q0_d  = q0_q;
    r0_d  = r0_q;
    if (pop_o) begin
      act_d = 1'b1;
      j_d   = '0;
      t_d   = '0;
      rem_d = '0;
      q0_d  = q0;
      r0_d  = r0;
    end else if (issue) begin
      if (is_last) begin
        act_d = 1'b0;
      end else begin
        j_d = j_q + SEG_W'(1);
        // carry the fractional part of 2^16/seg
        if (rem_sum >= {1'b0, seg_eff}) begin
          rem_d = SEG_W'(rem_sum - {1'b0, seg_eff});
          t_d   = t_q + q0_q + T_W'(1);
        end else begin
          rem_d = SEG_W'(rem_sum);
          t_d   = t_q + q0_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 1'b0;
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      v4_q  <= 1'b0;
      ov_q  <= 1'b0;
    end else begin
      act_q <= act_d;
      if (adv) begin
        v1_q <= issue;
        v2_q <= v1_q;
        v3_q <= v2_q;
        v4_q <= v3_q;
        ov_q <= v4_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    j_q   <= j_d;
    t_q   <= t_d;
    rem_q <= rem_d;
    q0_q  <= q0_d;
    r0_q  <= r0_d;
    if (pop_o) begin
      job_q <= head_job_i;
    end
    if (adv) begin
      c1_q <= job_q;
      t1_q <= t_q;
      l1_q <= is_last;
      t2_q <= t1_q;
      l2_q <= l1_q;
      t3_q <= t2_q;
      l3_q <= l2_q;
      l4_q <= l3_q;
      ol_q <= l4_q;
      for (int k = 0; k < 3; k++) begin
        s1_q[k] <= S1_W'(c1_q[k].d) * S1_W'(signed'({1'b0, t1_q}))
                   + (S1_W'(c1_q[k].c) <<< 16);
        b2_q[k] <= c1_q[k].b;
        a2_q[k] <= c1_q[k].a;
        s2_q[k] <= S2_W'(s1_q[k]) * S2_W'(signed'({1'b0, t2_q}))
                   + (S2_W'(b2_q[k]) <<< 32);
        a3_q[k] <= a2_q[k];
        s3_q[k] <= S3_W'(s2_q[k]) * S3_W'(signed'({1'b0, t3_q}))
                   + (S3_W'(a3_q[k]) <<< 48);
        o_q[k]  <= round_sat(s3_q[k]);
      end
    end
  end

  assign out_valid_o   = ov_q;
  assign out_last_o    = ol_q;
  assign out_point_o.x = o_q[0];
  assign out_point_o.y = o_q[1];
  assign out_point_o.z = o_q[2];

endmodule
